/* sv/i2c_eeprom_byte_word_access_defines.svh */
// assertion helpers, empty in synthesis
`ifndef I2C_EEPROM_BYTE_WORD_ACCESS_DEFINES_SVH
`define I2C_EEPROM_BYTE_WORD_ACCESS_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CEBW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CEBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CEBW_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CEBW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/i2cebw_pkg.sv */
package i2cebw_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_OFS = 1'd1;

  localparam logic [6:0] DEV_ADDR_RST = 7'd80;
  localparam logic [7:0] WORD_OFS_RST = 8'd40;

  localparam logic [3:0] WR_LEN = 4'd8;
  localparam logic [3:0] RD_LEN = 4'd11;

  typedef enum logic [2:0] {
    ACT_WR_BYTE = 3'd0,
    ACT_RD_BYTE = 3'd1,
    ACT_WR_WORD = 3'd2,
    ACT_RD_WORD = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_CMD,
    KIND_TICK
  } item_kind_t;

  typedef enum logic [3:0] {
    SEG_START,
    SEG_STOP,
    SEG_ACK,
    SEG_NOACK,
    SEG_WDEV,
    SEG_WADDR,
    SEG_WDATA,
    SEG_WDEVR,
    SEG_READ
  } seg_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [15:0] data;
    logic        sda;
  } item_t;

  function automatic seg_t seg_kind(input logic rd, input logic [3:0] idx);
    seg_t s;
    s = SEG_STOP;
    if (rd) begin
      case (idx)
        4'd0: s = SEG_START;
        4'd1: s = SEG_WDEV;
        4'd2: s = SEG_ACK;
        4'd3: s = SEG_WADDR;
        4'd4: s = SEG_ACK;
        4'd5: s = SEG_START;
        4'd6: s = SEG_WDEVR;
        4'd7: s = SEG_ACK;
        4'd8: s = SEG_READ;
        4'd9: s = SEG_NOACK;
        default: s = SEG_STOP;
      endcase
    end else begin
      case (idx)
        4'd0: s = SEG_START;
        4'd1: s = SEG_WDEV;
        4'd2: s = SEG_ACK;
        4'd3: s = SEG_WADDR;
        4'd4: s = SEG_ACK;
        4'd5: s = SEG_WDATA;
        4'd6: s = SEG_ACK;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

endpackage

/* sv/i2cebw_intf.sv */
interface i2cebw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  address;
  logic [15:0] write_data;
  logic        sda_in;

  modport source (output valid, action, address, write_data, sda_in, input ready);
  modport sink (input valid, action, address, write_data, sda_in, output ready);
endinterface

interface i2cebw_out_if;
  logic        valid;
  logic        ready;
  logic        scl;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_value;
  logic        ack_error;
  logic        command_rejected;

  modport source (output valid, scl, sda_drive, busy_res, done_res, read_value, ack_error,
                  command_rejected, input ready);
  modport sink (input valid, scl, sda_drive, busy_res, done_res, read_value, ack_error,
                command_rejected, output ready);
endinterface

/* sv/i2cebw_front.sv */
module i2cebw_front
  import i2cebw_pkg::*;
(
  i2cebw_in_if.sink in_bus,
  input  logic      q_full,
  output logic      push,
  output item_t     push_item
);

  item_kind_t kind;

  always_comb begin
    case (in_bus.action)
      ACT_WR_BYTE, ACT_RD_BYTE, ACT_WR_WORD, ACT_RD_WORD: kind = KIND_CMD;
      ACT_TICK: kind = KIND_TICK;
      default: kind = KIND_NOP;
    endcase
  end

  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

  assign push_item.kind = kind;
  assign push_item.op   = in_bus.action[1:0];
  assign push_item.addr = in_bus.address;
  assign push_item.data = in_bus.write_data;
  assign push_item.sda  = in_bus.sda_in;

endmodule

/* sv/i2cebw_queue.sv */
module i2cebw_queue
  import i2cebw_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  item_t           mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == DepthCnt);
  assign nonempty  = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/i2cebw_back.sv */
`include "i2c_eeprom_byte_word_access_defines.svh"

module i2cebw_back
  import i2cebw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_nonempty,
  input  item_t                 q_item,
  output logic                  q_pop,
  i2cebw_out_if.source          out_bus
);

  logic [6:0]  dev_r;
  logic [7:0]  ofs_r;

  logic [1:0]  op_r, op_nxt;
  logic [5:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        half_r, half_nxt;
  logic [7:0]  haddr_r, haddr_nxt;
  logic [15:0] hdata_r, hdata_nxt;
  logic [15:0] racc_r, racc_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ackf_r, ackf_nxt;

  logic        ov_r;
  logic        o_busy_r, o_done_r, o_ackerr_r, o_rej_r;
  logic [15:0] o_value_r;

  logic        done, rejected;
  logic [15:0] value;

  assign q_pop = q_nonempty && (!ov_r || out_bus.ready);

  always_comb begin
    logic [5:0] ph_m1;
    logic [3:0] seg, seg_p1, cnt_p1, len;
    logic [1:0] sub;
    logic       rd, word, fin, seg_end, stay;
    logic [7:0] bsel, sh;
    seg_t       kind;

    op_nxt    = op_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    half_nxt  = half_r;
    haddr_nxt = haddr_r;
    hdata_nxt = hdata_r;
    racc_nxt  = racc_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackf_nxt  = ackf_r;
    done      = 1'b0;
    rejected  = 1'b0;
    value     = '0;

    ph_m1   = phase_r - 6'd1;
    seg     = ph_m1[5:2];
    sub     = ph_m1[1:0];
    seg_p1  = seg + 4'd1;
    cnt_p1  = cnt_r + 4'd1;
    rd      = op_r[0];
    word    = op_r[1];
    len     = rd ? RD_LEN : WR_LEN;
    kind    = seg_kind(rd, seg);
    fin     = 1'b0;
    seg_end = 1'b0;
    stay    = 1'b0;
    sh      = {shift_r[6:0], q_item.sda};

    case (kind)
      SEG_WDEV:  bsel = {dev_r, 1'b0};
      SEG_WDEVR: bsel = {dev_r, 1'b1};
      SEG_WADDR: bsel = (word && half_r) ? haddr_r + ofs_r : haddr_r;
      default:   bsel = (word && !half_r) ? hdata_r[15:8] : hdata_r[7:0];
    endcase

    if (q_item.kind == KIND_CMD) begin
      if (phase_r != '0) begin
        rejected = 1'b1;
      end else begin
        op_nxt    = q_item.op;
        haddr_nxt = q_item.addr;
        hdata_nxt = q_item.data;
        phase_nxt = 6'd1;
        cnt_nxt   = '0;
        shift_nxt = '0;
        half_nxt  = 1'b0;
        racc_nxt  = '0;
        ackf_nxt  = 1'b0;
      end
    end else if (q_item.kind == KIND_TICK && phase_r != '0) begin
      if (seg >= len) begin
        fin = 1'b1;
      end else begin
        case (kind)
          SEG_START: begin
            case (sub)
              2'd0: sda_nxt = 1'b1;
              2'd1: scl_nxt = 1'b1;
              2'd2: sda_nxt = 1'b0;
              default: begin
                scl_nxt = 1'b0;
                seg_end = 1'b1;
              end
            endcase
          end
          SEG_STOP: begin
            case (sub)
              2'd0: scl_nxt = 1'b0;
              2'd1: sda_nxt = 1'b0;
              2'd2: scl_nxt = 1'b1;
              default: begin
                sda_nxt = 1'b1;
                seg_end = 1'b1;
              end
            endcase
          end
          SEG_ACK, SEG_NOACK: begin
            if (sub == 2'd0) begin
              sda_nxt = 1'b1;
            end else if (sub == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              if (kind == SEG_ACK && q_item.sda) begin
                ackf_nxt = 1'b1;
              end
              scl_nxt = 1'b0;
              seg_end = 1'b1;
            end
          end
          SEG_READ: begin
            if (sub == 2'd0) begin
              if (cnt_r == '0) begin
                shift_nxt = '0;
              end
              scl_nxt = 1'b1;
            end else begin
              shift_nxt = sh;
              scl_nxt   = 1'b0;
              if (cnt_p1 >= 4'd8) begin
                cnt_nxt = '0;
                if (word && !half_r) begin
                  racc_nxt = {sh, 8'h00};
                end else begin
                  racc_nxt = racc_r | {8'h00, sh};
                end
                seg_end = 1'b1;
              end else begin
                cnt_nxt   = cnt_p1;
                phase_nxt = phase_r - 6'd1;
                stay      = 1'b1;
              end
            end
          end
          default: begin
            if (sub == 2'd0) begin
              if (cnt_r == '0) begin
                shift_nxt = bsel;
                sda_nxt   = bsel[7];
              end else begin
                sda_nxt = shift_r[7];
              end
            end else if (sub == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt   = 1'b0;
              shift_nxt = {shift_r[6:0], 1'b0};
              if (cnt_p1 >= 4'd8) begin
                cnt_nxt = '0;
                seg_end = 1'b1;
              end else begin
                cnt_nxt   = cnt_p1;
                phase_nxt = phase_r - 6'd2;
                stay      = 1'b1;
              end
            end
          end
        endcase
      end

      if (!fin && !stay) begin
        if (!seg_end) begin
          phase_nxt = phase_r + 6'd1;
        end else if (seg_p1 < len) begin
          phase_nxt = {seg_p1, 2'b00} + 6'd1;
        end else if (word && !half_r) begin
          half_nxt  = 1'b1;
          phase_nxt = 6'd1;
        end else begin
          fin = 1'b1;
        end
      end

      if (fin) begin
        done      = 1'b1;
        value     = rd ? racc_nxt : '0;
        phase_nxt = '0;
        cnt_nxt   = '0;
        half_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= DEV_ADDR_RST;
      ofs_r   <= WORD_OFS_RST;
      op_r    <= '0;
      phase_r <= '0;
      cnt_r   <= '0;
      shift_r <= '0;
      half_r  <= 1'b0;
      haddr_r <= '0;
      hdata_r <= '0;
      racc_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackf_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DEV_ADDR: dev_r <= cfg_wdata[6:0];
          REG_WORD_OFS: ofs_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (q_pop) begin
        op_r    <= op_nxt;
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        shift_r <= shift_nxt;
        half_r  <= half_nxt;
        haddr_r <= haddr_nxt;
        hdata_r <= hdata_nxt;
        racc_r  <= racc_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ackf_r  <= ackf_nxt;
        ov_r    <= 1'b1;
      end else if (out_bus.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_busy_r   <= (phase_nxt != '0);
      o_done_r   <= done;
      o_value_r  <= value;
      o_ackerr_r <= ackf_nxt;
      o_rej_r    <= rejected;
    end
  end

  assign out_bus.valid            = ov_r;
  assign out_bus.scl              = scl_r;
  assign out_bus.sda_drive        = sda_r;
  assign out_bus.busy_res         = o_busy_r;
  assign out_bus.done_res         = o_done_r;
  assign out_bus.read_value       = o_value_r;
  assign out_bus.ack_error        = o_ackerr_r;
  assign out_bus.command_rejected = o_rej_r;

  `I2CEBW_ASSERT(a_idle_lines_high, clk, rst_n, (phase_r == '0) |-> (scl_r && sda_r), "lines not released while idle")
  `I2CEBW_ASSERT(a_bit_cnt_range, clk, rst_n, cnt_r < 4'd8, "bit counter out of range")
  `I2CEBW_ASSERT(a_done_not_busy, clk, rst_n, (ov_r && o_done_r) |-> !o_busy_r, "done while still busy")
  `I2CEBW_ASSERT(a_reject_needs_busy, clk, rst_n, (ov_r && o_rej_r) |-> (o_busy_r && !o_done_r), "reject while idle")
  `I2CEBW_ASSERT(a_state_holds_on_stall, clk, rst_n, !$past(q_pop) |-> $stable(phase_r), "state moved without a step")

endmodule

/* sv/i2c_eeprom_byte_word_access.sv */
// channel   dir  handshake          payload
// in_bus    in   valid/ready        action, address, write_data, sda_in
// out_bus   out  valid/ready        scl, sda_drive, busy_res, done_res, read_value,
//                                   ack_error, command_rejected
// cfg       in   cfg_we             cfg_idx, cfg_wdata
//
// one transaction in, one transaction out; each item is one step of the back end
// in to out passes the queue entry, then the output register; one item per cycle when out_bus.ready stays high
// in_bus.ready drops only when the command queue is full behind a stalled out_bus
// synchronous active-low reset; lines reset released, address 80, offset 40
module i2c_eeprom_byte_word_access
  import i2cebw_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cebw_in_if.sink             in_bus,
  i2cebw_out_if.source          out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic  push, q_full, q_pop, q_nonempty;
  item_t push_item, head_item;

  i2cebw_front u_front (
    .in_bus    (in_bus),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  i2cebw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head_item (head_item)
  );

  i2cebw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .q_nonempty (q_nonempty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_bus    (out_bus)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import i2cebw_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  address;
    logic [15:0] write_data;
    logic        sda_in;
  } bus_cmd_t;

  typedef struct packed {
    logic        scl;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic        ack_error;
    logic        command_rejected;
  } bus_step_t;

  typedef struct {
    bus_cmd_t  cmd;
    bit        until_idle;
    bit        pinned;
    bus_step_t want;
  } directed_row_t;

  typedef struct {
    int         idle;
    int         stall;
    bit         rand_cfg;
    logic [7:0] dev_wdata;
    logic [7:0] ofs;
  } test_phase_t;

  localparam bus_step_t RES_IDLE    = {1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0};
  localparam bus_step_t RES_LATCHED = {1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0};
  localparam bus_step_t RES_REJECT  = {1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1};
  localparam int DIR_ROWS = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2cebw_in_if in_bus ();
  i2cebw_out_if out_bus ();

  i2c_eeprom_byte_word_access dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // bus master model
  seg_t write_frame [8] = '{SEG_START, SEG_WDEV, SEG_ACK, SEG_WADDR, SEG_ACK, SEG_WDATA,
                            SEG_ACK, SEG_STOP};
  seg_t read_frame [11] = '{SEG_START, SEG_WDEV, SEG_ACK, SEG_WADDR, SEG_ACK, SEG_START,
                            SEG_WDEVR, SEG_ACK, SEG_READ, SEG_NOACK, SEG_STOP};

  logic [6:0]  dev_addr;
  logic [7:0]  word_ofs;
  logic [1:0]  cur_op;
  logic [5:0]  step_no;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic        second_half;
  logic [7:0]  addr_hold;
  logic [15:0] data_hold;
  logic [15:0] rd_acc;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_bad;

  bus_step_t pending_bus_steps [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int sda_mode = 0;

  function automatic void reset_bus_model();
    dev_addr = DEV_ADDR_RST;
    word_ofs = WORD_OFS_RST;
    cur_op = 2'd0;
    step_no = 6'd0;
    bit_cnt = 4'd0;
    shreg = 8'd0;
    second_half = 1'b0;
    addr_hold = 8'd0;
    data_hold = 16'd0;
    rd_acc = 16'd0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    ack_bad = 1'b0;
  endfunction

  function automatic logic [7:0] frame_byte(input seg_t kind);
    logic word;
    word = cur_op[1];
    case (kind)
      SEG_WDEV:  return {dev_addr, 1'b0};
      SEG_WDEVR: return {dev_addr, 1'b1};
      SEG_WADDR: return (word && second_half) ? addr_hold + word_ofs : addr_hold;
      default:   return (word && !second_half) ? data_hold[15:8] : data_hold[7:0];
    endcase
  endfunction

  // one line change, returns 1 when the transaction ends
  function automatic logic bus_line_step(input logic sda);
    int seg;
    int sub;
    int len;
    logic rd;
    logic word;
    logic seg_end;
    seg_t kind;
    seg = (int'(step_no) - 1) >> 2;
    sub = (int'(step_no) - 1) & 3;
    rd = cur_op[0];
    word = cur_op[1];
    len = rd ? int'(RD_LEN) : int'(WR_LEN);
    seg_end = 1'b0;
    if (seg >= len) return 1'b1;
    kind = rd ? read_frame[seg] : write_frame[seg];
    case (kind)
      SEG_START: begin
        case (sub)
          0: sda_lvl = 1'b1;
          1: scl_lvl = 1'b1;
          2: sda_lvl = 1'b0;
          default: begin
            scl_lvl = 1'b0;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_STOP: begin
        case (sub)
          0: scl_lvl = 1'b0;
          1: sda_lvl = 1'b0;
          2: scl_lvl = 1'b1;
          default: begin
            sda_lvl = 1'b1;
            seg_end = 1'b1;
          end
        endcase
      end
      SEG_ACK, SEG_NOACK: begin
        if (sub == 0) sda_lvl = 1'b1;
        else if (sub == 1) scl_lvl = 1'b1;
        else begin
          if (kind == SEG_ACK && sda) ack_bad = 1'b1;
          scl_lvl = 1'b0;
          seg_end = 1'b1;
        end
      end
      SEG_READ: begin
        if (sub == 0) begin
          if (bit_cnt == 4'd0) shreg = 8'd0;
          scl_lvl = 1'b1;
        end else begin
          shreg = {shreg[6:0], sda};
          scl_lvl = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = 4'd0;
            if (word && !second_half) rd_acc = {shreg, 8'h00};
            else rd_acc = rd_acc | {8'h00, shreg};
            seg_end = 1'b1;
          end else begin
            step_no = step_no - 6'd1;
            return 1'b0;
          end
        end
      end
      default: begin
        if (sub == 0) begin
          if (bit_cnt == 4'd0) shreg = frame_byte(kind);
          sda_lvl = shreg[7];
        end else if (sub == 1) begin
          scl_lvl = 1'b1;
        end else begin
          scl_lvl = 1'b0;
          shreg = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = 4'd0;
            seg_end = 1'b1;
          end else begin
            step_no = step_no - 6'd2;
            return 1'b0;
          end
        end
      end
    endcase
    if (!seg_end) begin
      step_no = step_no + 6'd1;
      return 1'b0;
    end
    if (seg + 1 < len) begin
      step_no = 6'(1 + (seg + 1) * 4);
      return 1'b0;
    end
    if (word && !second_half) begin
      second_half = 1'b1;
      step_no = 6'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bus_step_t predict_bus_step(input bus_cmd_t it);
    bus_step_t r;
    r = '0;
    if (it.action <= ACT_RD_WORD) begin
      if (step_no != 6'd0) begin
        r.command_rejected = 1'b1;
      end else begin
        cur_op = it.action[1:0];
        addr_hold = it.address;
        data_hold = it.write_data;
        step_no = 6'd1;
        bit_cnt = 4'd0;
        shreg = 8'd0;
        second_half = 1'b0;
        rd_acc = 16'd0;
        ack_bad = 1'b0;
      end
    end else if (it.action == ACT_TICK && step_no != 6'd0) begin
      if (bus_line_step(it.sda_in)) begin
        r.done_res = 1'b1;
        r.read_value = cur_op[0] ? rd_acc : 16'd0;
        step_no = 6'd0;
        bit_cnt = 4'd0;
        second_half = 1'b0;
      end
    end
    r.scl = scl_lvl;
    r.sda_drive = sda_lvl;
    r.busy_res = (step_no != 6'd0);
    r.ack_error = ack_bad;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: compare, then decide the next stall
  always @(posedge clk) begin
    bus_step_t got;
    bus_step_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.scl, out_bus.sda_drive, out_bus.busy_res, out_bus.done_res,
             out_bus.read_value, out_bus.ack_error, out_bus.command_rejected};
      if (pending_bus_steps.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_bus_steps.pop_front();
        check_field("scl", 16'(want.scl), 16'(got.scl));
        check_field("sda_drive", 16'(want.sda_drive), 16'(got.sda_drive));
        check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(got.done_res));
        check_field("read_value", want.read_value, got.read_value);
        check_field("ack_error", 16'(want.ack_error), 16'(got.ack_error));
        check_field("command_rejected", 16'(want.command_rejected),
                    16'(got.command_rejected));
      end
    end
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_cmd(input bus_cmd_t it, input bit pinned, input bus_step_t want);
    bus_step_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= it.action;
    in_bus.address <= it.address;
    in_bus.write_data <= it.write_data;
    in_bus.sda_in <= it.sda_in;
    do @(posedge clk); while (!in_bus.ready);
    r = predict_bus_step(it);
    pending_bus_steps.push_back(pinned ? want : r);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_bus_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dev_wdata, input logic [7:0] ofs);
    cfg_we <= 1'b1;
    cfg_idx <= REG_DEV_ADDR;
    cfg_wdata <= dev_wdata;
    @(posedge clk);
    dev_addr = dev_wdata[6:0];
    cfg_idx <= REG_WORD_OFS;
    cfg_wdata <= ofs;
    @(posedge clk);
    word_ofs = ofs;
    cfg_we <= 1'b0;
  endtask

  directed_row_t directed_rows [DIR_ROWS] = '{
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b1}, 1'b0, 1'b1, RES_IDLE},
    '{'{3'd5, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_IDLE},
    '{'{3'd7, 8'hff, 16'hffff, 1'b1}, 1'b0, 1'b1, RES_IDLE},
    '{'{ACT_WR_BYTE, 8'hff, 16'hffff, 1'b0}, 1'b0, 1'b1, RES_LATCHED},
    '{'{ACT_RD_WORD, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_REJECT},
    '{'{3'd6, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_LATCHED},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b0}, 1'b1, 1'b0, RES_IDLE},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_IDLE},
    '{'{ACT_RD_BYTE, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_LATCHED},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b1}, 1'b1, 1'b0, RES_IDLE},
    '{'{ACT_WR_WORD, 8'hff, 16'ha55a, 1'b0}, 1'b0, 1'b1, RES_LATCHED},
    '{'{ACT_WR_BYTE, 8'h00, 16'hffff, 1'b1}, 1'b0, 1'b1, RES_REJECT},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b0}, 1'b1, 1'b0, RES_IDLE},
    '{'{ACT_RD_WORD, 8'hff, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_LATCHED},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b0}, 1'b1, 1'b0, RES_IDLE},
    '{'{ACT_TICK, 8'h00, 16'h0000, 1'b0}, 1'b0, 1'b1, RES_IDLE}
  };

  test_phase_t test_phases [4] = '{
    '{0, 0, 1'b0, 8'h00, 8'hff},
    '{86, 0, 1'b0, 8'hff, 8'h00},
    '{0, 86, 1'b1, 8'h00, 8'h00},
    '{27, 27, 1'b0, 8'h50, 8'h28}
  };

  initial begin
    bus_cmd_t it;
    logic [7:0] dev_w;
    logic [7:0] ofs_w;
    int counted;
    int r;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_DEV_ADDR;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_TICK;
    in_bus.address <= 8'd0;
    in_bus.write_data <= 16'd0;
    in_bus.sda_in <= 1'b1;
    reset_bus_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].until_idle) begin
        do send_cmd(directed_rows[i].cmd, 1'b0, RES_IDLE); while (step_no != 6'd0);
      end else begin
        send_cmd(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    foreach (test_phases[p]) begin
      drain();
      dev_w = test_phases[p].dev_wdata;
      ofs_w = test_phases[p].ofs;
      if (test_phases[p].rand_cfg) begin
        dev_w = 8'($urandom);
        ofs_w = 8'($urandom);
      end
      set_config(dev_w, ofs_w);
      idle_pct = test_phases[p].idle;
      stall_pct = test_phases[p].stall;
      counted = 0;
      while (counted < 22) begin
        r = $urandom_range(99);
        it.address = 8'($urandom);
        it.write_data = 16'($urandom);
        case (sda_mode)
          0: it.sda_in = 1'b0;
          1: it.sda_in = 1'($urandom_range(1));
          default: it.sda_in = ($urandom_range(9) == 0);
        endcase
        if (step_no == 6'd0) begin
          if (r < 5) begin
            it.action = ACT_TICK;
          end else if (r < 10) begin
            it.action = 3'($urandom_range(7, 5));
          end else begin
            it.action = 3'($urandom_range(3));
            sda_mode = $urandom_range(2);
            counted++;
          end
        end else begin
          if (r < 4) it.action = 3'($urandom_range(3));
          else if (r < 7) it.action = 3'($urandom_range(7, 5));
          else it.action = ACT_TICK;
          if (r < 4 || r >= 7) counted++;
        end
        send_cmd(it, 1'b0, RES_IDLE);
      end
    end

    drain();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
